// ===== rtl/hfh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hfh_pkg;
    localparam int DEF_MAX_PAYLOAD = 48;
    localparam int HDR_LEN = 14;
    localparam logic [7:0] START_BYTE = 8'h10;
    localparam logic [7:0] TAIL_BYTE = 8'h16;

    localparam logic [1:0] CFG_MSB_FIRST = 2'd0;
    localparam logic [1:0] CFG_ID_FILTER = 2'd1;
    localparam logic [1:0] CFG_EXPECT_ID = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_HOLD
    } t_state;
endpackage
`default_nettype wire

// ===== rtl/hfh_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hfh_store #(
    parameter int DEPTH = 64,
    parameter int AW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/header_checksum_frame_hunter.sv =====
// channel  | dir | payload
// s_axis   | in  | tdata: rx_byte
// m_axis   | out | tdata: header fields, payload byte; tuser: byte_valid; tlast: last
// cfg      | in  | we / addr / wdata, registers 0..2
// A byte is taken only when the block is idle; each candidate byte is then examined
// by a store read and an evaluate step, and one more store read finds the scan
// caught up. A failed candidate replays its held bytes. Each emitted item is read,
// loaded, then held until the output takes it. Reset is synchronous.
`timescale 1ns / 1ps
`default_nettype none
module header_checksum_frame_hunter
    import hfh_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [7:0]   i_s_tdata,   // rx_byte
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // station_addr, term_kind, proto_kind, ctrl_code, point_id, data_id,
    // payload_len, payload_byte, zero pad
    output logic      [103:0] o_m_tdata,
    output logic      [0:0]   o_m_tuser,   // byte_valid
    output logic              o_m_tlast,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_addr,
    input  wire logic [15:0]  i_cfg_wdata
);
    localparam int DEPTH = MAX_PAYLOAD + 16;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = $clog2(MAX_PAYLOAD + 1);

    t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_scan, n_scan;
    logic [7:0]    r_sum, n_sum;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_k, n_k;
    logic [7:0]    r_hdr [1:13];
    logic          r_msb, r_filt;
    logic [15:0]   r_expect;
    logic          r_oval, n_oval;
    logic [7:0]    r_opay, n_opay;
    logic          r_obv, n_obv;
    logic          r_olast, n_olast;

    logic          acc;
    logic [AW-1:0] raddr, waddr;
    logic [7:0]    rdata;
    logic [15:0]   len16, f_addr, f_term, f_proto, f_point, f_data, len_ext;
    logic [CW-1:0] pl_end, need;
    logic          fail, good, filtered, hdr_we, last_item;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [15:0] get16(input logic msb, input logic [7:0] a,
                                          input logic [7:0] b);
        return msb ? {a, b} : {b, a};
    endfunction

    assign acc = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign waddr = wrap_add(r_head, r_count);
    assign raddr = (r_state == S_EMIT_RD) ?
                   wrap_add(r_head, CW'(HDR_LEN) + CW'(r_k)) :
                   wrap_add(r_head, r_scan);

    hfh_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (acc),
        .i_waddr(waddr),
        .i_wdata(i_s_tdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign len16   = get16(r_msb, r_hdr[12], rdata);
    assign f_addr  = get16(r_msb, r_hdr[1], r_hdr[2]);
    assign f_term  = get16(r_msb, r_hdr[3], r_hdr[4]);
    assign f_proto = get16(r_msb, r_hdr[5], r_hdr[6]);
    assign f_point = get16(r_msb, r_hdr[8], r_hdr[9]);
    assign f_data  = get16(r_msb, r_hdr[10], r_hdr[11]);
    assign len_ext = 16'(r_len);
    assign pl_end  = CW'(HDR_LEN) + CW'(r_len);
    assign need    = CW'(HDR_LEN + 2) + CW'(r_len);
    assign filtered = r_filt && (f_data != r_expect);
    assign last_item = (r_len == '0) || ((LW+1)'(r_k) + 1'b1 == (LW+1)'(r_len));

    always_comb begin
        fail = 1'b0;
        good = 1'b0;
        hdr_we = 1'b0;
        if (r_state == S_SCAN_EV) begin
            if (r_scan == '0) begin
                fail = (rdata != START_BYTE);
            end else if (r_scan < CW'(HDR_LEN)) begin
                hdr_we = 1'b1;
                if (r_scan == CW'(HDR_LEN - 1)) begin
                    fail = (len16 > 16'(MAX_PAYLOAD));
                end
            end else if (r_scan == pl_end) begin
                fail = (rdata != r_sum);
            end else if (r_scan == pl_end + 1'b1) begin
                fail = (rdata != TAIL_BYTE);
                good = !fail;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (acc) n_state = S_SCAN_RD;
            S_SCAN_RD:   n_state = (r_scan < r_count) ? S_SCAN_EV : S_IDLE;
            S_SCAN_EV:   n_state = (good && !filtered) ? S_EMIT_RD : S_SCAN_RD;
            S_EMIT_RD:   n_state = S_EMIT_LD;
            S_EMIT_LD:   n_state = S_EMIT_HOLD;
            S_EMIT_HOLD: begin
                if (i_m_tready) n_state = last_item ? S_SCAN_RD : S_EMIT_RD;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_scan  = r_scan;
        n_sum   = r_sum;
        n_len   = r_len;
        n_k     = r_k;
        n_oval  = r_oval;
        n_opay  = r_opay;
        n_obv   = r_obv;
        n_olast = r_olast;
        case (r_state)
            S_IDLE: begin
                if (acc) n_count = r_count + 1'b1;
                // new settings: decode held bytes again from the start
                if (i_cfg_we) begin
                    n_scan = '0;
                    n_sum  = '0;
                end
            end
            S_SCAN_EV: begin
                n_scan = r_scan + 1'b1;
                if (r_scan < pl_end) n_sum = r_sum + rdata;
                if (r_scan == CW'(HDR_LEN - 1)) n_len = LW'(len16);
                if (fail) begin
                    n_head  = wrap_add(r_head, CW'(1));
                    n_count = r_count - 1'b1;
                    n_scan  = '0;
                    n_sum   = '0;
                end else if (good) begin
                    n_k = '0;
                    if (filtered) begin
                        n_head  = wrap_add(r_head, need);
                        n_count = r_count - need;
                        n_scan  = '0;
                        n_sum   = '0;
                    end
                end
            end
            S_EMIT_LD: begin
                n_oval  = 1'b1;
                n_opay  = (r_len == '0) ? 8'd0 : rdata;
                n_obv   = (r_len != '0);
                n_olast = last_item;
            end
            S_EMIT_HOLD: begin
                if (i_m_tready) begin
                    n_oval = 1'b0;
                    n_k = r_k + 1'b1;
                    if (last_item) begin
                        n_head  = wrap_add(r_head, need);
                        n_count = r_count - need;
                        n_scan  = '0;
                        n_sum   = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_scan   <= '0;
            r_sum    <= '0;
            r_len    <= '0;
            r_k      <= '0;
            r_oval   <= 1'b0;
            r_msb    <= 1'b0;
            r_filt   <= 1'b0;
            r_expect <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_scan  <= n_scan;
            r_sum   <= n_sum;
            r_len   <= n_len;
            r_k     <= n_k;
            r_oval  <= n_oval;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_MSB_FIRST: r_msb    <= i_cfg_wdata[0];
                    CFG_ID_FILTER: r_filt   <= i_cfg_wdata[0];
                    CFG_EXPECT_ID: r_expect <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_opay  <= n_opay;
        r_obv   <= n_obv;
        r_olast <= n_olast;
        if (hdr_we) r_hdr[r_scan[3:0]] <= rdata;
    end

    assign o_m_tvalid = r_oval;
    assign o_m_tuser  = r_obv;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {2'b00, r_opay, len_ext[5:0], f_data, f_point, r_hdr[7],
                         f_proto, f_term, f_addr};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("store overfilled");
    a_no_take_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready) else $error("input taken during emission");
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_state == S_EMIT_HOLD) else $error("output valid outside hold");
    a_out_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready) |=> !o_m_tvalid) else $error("item repeated");
`endif
endmodule
`default_nettype wire

// ===== bench/header_checksum_frame_hunter_test.sv =====
`timescale 1ns / 1ps
module header_checksum_frame_hunter_test;
    import hfh_pkg::*;

    localparam int MAXP = DEF_MAX_PAYLOAD;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 500;

    typedef struct packed {
        logic         last;
        logic         byte_valid;
        logic [103:0] data;
    } t_frame_item;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [7:0]   i_s_tdata = 8'h00;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [103:0] o_m_tdata;
    logic [0:0]   o_m_tuser;
    logic         o_m_tlast;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_addr = CFG_MSB_FIRST;
    logic [15:0]  i_cfg_wdata = 16'h0000;

    header_checksum_frame_hunter uut (.*);

    always #4 i_clk = ~i_clk;

    // shadow of block state
    logic [7:0]  held[$];
    logic        msb_first = 1'b0;
    logic        id_filter = 1'b0;
    logic [15:0] want_id = 16'h0000;

    logic [7:0]  rx_pending[$];
    t_frame_item frame_items[$];
    int          fail_count = 0;
    int          idle_mode = 0;   // 0: sender 26/recv 65, 1: swapped, 2: none
    logic        stall_armed = 1'b0;
    int          stall_left = 0;
    logic        stall_used = 1'b0;
    longint      cycles = 0;

    function automatic logic [15:0] held16(int pos);
        return msb_first ? {held[pos], held[pos+1]} : {held[pos+1], held[pos]};
    endfunction

    task automatic deframe_byte(logic [7:0] b);
        int len, need, n;
        logic [7:0] sum;
        t_frame_item it;
        held.push_back(b);
        while (held.size() > 0) begin
            if (held[0] != START_BYTE) begin
                void'(held.pop_front());
                continue;
            end
            if (held.size() < HDR_LEN) break;
            len = held16(12);
            if (len > MAXP) begin
                void'(held.pop_front());
                continue;
            end
            need = HDR_LEN + 2 + len;
            if (held.size() < need) break;
            sum = 8'h00;
            for (int k = 0; k < HDR_LEN + len; k++) sum += held[k];
            if (sum != held[HDR_LEN+len] || held[HDR_LEN+len+1] != TAIL_BYTE) begin
                void'(held.pop_front());
                continue;
            end
            if (!(id_filter && held16(10) != want_id)) begin
                n = (len == 0) ? 1 : len;
                for (int k = 0; k < n; k++) begin
                    it.data = {2'b00,
                               (len == 0) ? 8'h00 : held[HDR_LEN+k],
                               6'(len), held16(10), held16(8), held[7],
                               held16(5), held16(3), held16(1)};
                    it.byte_valid = (len != 0);
                    it.last = (k == n - 1);
                    frame_items.push_back(it);
                end
            end
            for (int k = 0; k < need; k++) void'(held.pop_front());
        end
    endtask

    // kind: 0 good, 1 bad checksum, 2 bad tail, 3 oversize length
    task automatic queue_frame(int len, int kind, logic [15:0] did);
        logic [7:0] f[$];
        logic [7:0] sum;
        logic [15:0] lf;
        logic [15:0] w;
        lf = (kind == 3) ? 16'($urandom_range(MAXP + 1, 65535)) : 16'(len);
        if (kind == 3 && $urandom_range(0, 1)) lf = 16'(MAXP + 1);
        f.push_back(START_BYTE);
        for (int k = 0; k < 6; k++) begin
            w = (k == 3) ? 16'($urandom) : (k == 4) ? did : (k == 5) ? lf : 16'($urandom);
            if (k == 2) begin
                f.push_back(w[7:0]);
                f.push_back(w[15:8]);
                f.push_back(8'($urandom));   // control byte
            end else if (msb_first) begin
                f.push_back(w[15:8]);
                f.push_back(w[7:0]);
            end else begin
                f.push_back(w[7:0]);
                f.push_back(w[15:8]);
            end
        end
        for (int k = 0; k < len; k++) f.push_back(8'($urandom));
        sum = 8'h00;
        foreach (f[k]) sum += f[k];
        f.push_back((kind == 1) ? sum ^ 8'(1 << $urandom_range(0, 7)) : sum);
        f.push_back((kind == 2) ? 8'($urandom_range(0, 255)) ^ 8'h01 : TAIL_BYTE);
        if (kind == 2 && f[f.size()-1] == TAIL_BYTE) f[f.size()-1] = 8'h17;
        foreach (f[k]) rx_pending.push_back(f[k]);
    endtask

    task automatic queue_random(int nbytes);
        int len, kind;
        logic [15:0] did;
        int sent;
        sent = 0;
        while (sent < nbytes) begin
            case ($urandom_range(0, 9))
                0: begin
                    rx_pending.push_back(8'($urandom));
                    sent++;
                end
                1: begin
                    // truncated frame start
                    rx_pending.push_back(START_BYTE);
                    for (int k = 0; k < $urandom_range(1, 8); k++)
                        rx_pending.push_back(8'($urandom));
                    sent += 5;
                end
                default: begin
                    len = ($urandom_range(0, 19) == 0) ? MAXP : $urandom_range(0, 6);
                    kind = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
                    did = $urandom_range(0, 1) ? want_id : 16'($urandom);
                    queue_frame(len, kind, did);
                    sent += len + 16;
                end
            endcase
        end
    endtask

    task automatic write_reg(logic [1:0] addr, logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            CFG_MSB_FIRST: msb_first = value[0];
            CFG_ID_FILTER: id_filter = value[0];
            default:       want_id = value;
        endcase
    endtask

    task automatic wait_idle();
        while (rx_pending.size() > 0 || i_s_tvalid || frame_items.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // sender
    always @(posedge i_clk) begin
        logic go;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) deframe_byte(i_s_tdata);
            if (!i_s_tvalid || o_s_tready) begin
                go = rx_pending.size() > 0 &&
                     !(idle_mode == 0 && $urandom_range(0, 99) < 26) &&
                     !(idle_mode == 1 && $urandom_range(0, 99) < 65);
                if (go) i_s_tdata <= rx_pending.pop_front();
                i_s_tvalid <= go;
            end
        end
    end

    // receiver back-pressure, with one long hold-off
    always @(posedge i_clk) begin
        if (stall_armed && !stall_used) begin
            stall_used <= 1'b1;
            stall_left <= 3000;
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= !(idle_mode == 0 && $urandom_range(0, 99) < 65) &&
                          !(idle_mode == 1 && $urandom_range(0, 99) < 26);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_frame_item got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tlast, o_m_tuser[0], o_m_tdata};
            if (frame_items.size() == 0) begin
                $display("%0t: unexpected item %h", $time, got);
                fail_count++;
            end else begin
                want = frame_items.pop_front();
                if (got.data !== want.data || got.byte_valid !== want.byte_valid ||
                    got.last !== want.last) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** header_checksum_frame_hunter: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(CFG_MSB_FIRST, 16'h0000);
        write_reg(CFG_ID_FILTER, 16'h0000);
        write_reg(CFG_EXPECT_ID, 16'h0000);

        // directed: noise, empty frame, max frame, each failure kind
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        queue_frame(0, 0, 16'h0000);
        queue_frame(MAXP, 0, 16'hFFFF);
        queue_frame(2, 1, 16'h1234);
        queue_frame(1, 2, 16'h5678);
        queue_frame(3, 3, 16'h0001);
        queue_frame(1, 0, 16'h00FF);
        queue_random(30);
        wait_idle();

        idle_mode = 1;
        write_reg(CFG_MSB_FIRST, 16'h0001);
        write_reg(CFG_ID_FILTER, 16'h0001);
        write_reg(CFG_EXPECT_ID, 16'hFFFF);
        queue_random(30);
        wait_idle();

        idle_mode = 2;
        write_reg(CFG_MSB_FIRST, 16'h0000);
        write_reg(CFG_EXPECT_ID, 16'h0000);
        stall_armed = 1'b1;
        queue_random(20);
        wait_idle();

        write_reg(CFG_ID_FILTER, 16'h0000);
        write_reg(CFG_EXPECT_ID, 16'($urandom));
        queue_random(15);
        wait_idle();

        if (fail_count == 0 && frame_items.size() == 0) begin
            $display("** header_checksum_frame_hunter: PASSED **");
        end else begin
            $display("** header_checksum_frame_hunter: FAILED **");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/hfh_pkg.sv
rtl/hfh_store.sv
rtl/header_checksum_frame_hunter.sv
bench/header_checksum_frame_hunter_test.sv
